[hdl/raa_pkg.sv]
// Shared types and constants of the rectangle area allocator.
// Payload structs, config register indices, datapath command codes, status bundle and sequencer states.
// No dependencies.
`default_nettype none
package raa_pkg;

	localparam int FIELD_W = 13;
	localparam int FREE_SLOTS_DEF = 64;
	localparam int COORD_MAX_DEF = 4096;
	localparam int RESET_ATLAS = 1024;

	typedef struct packed {
		logic operation;
		logic [FIELD_W-1:0] req_width;
		logic [FIELD_W-1:0] req_height;
	} in_item_t;

	typedef struct packed {
		logic granted;
		logic [FIELD_W-1:0] pos_x;
		logic [FIELD_W-1:0] pos_y;
		logic table_overflow;
	} out_item_t;

	typedef enum logic [0:0] {
		REG_ATLAS_WIDTH = 1'b0,
		REG_ATLAS_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_RESTART,
		OP_LOAD_REQ,
		OP_RD_IDX,
		OP_SCAN_EV,
		OP_CUT_START,
		OP_CUT_EV,
		OP_SPLIT,
		OP_MOVE_START,
		OP_MOVE_RD,
		OP_MOVE_WR,
		OP_SW_START,
		OP_I_NEXT,
		OP_I_EV,
		OP_J_RD,
		OP_J_NEXT,
		OP_J_EV,
		OP_CMP_START,
		OP_CMP_WR,
		OP_CMP_END,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		logic idx_end;
		logic j_end;
		logic idx_dead;
		logic j_dead;
		logic found;
		logic overlap;
		logic split_last;
		logic move_end;
		logic i_in_j;
		logic out_busy;
	} dp_status_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_RESTART,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_CUT_RD,
		ST_CUT_EV,
		ST_SPLIT,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_I_RD,
		ST_I_EV,
		ST_J_RD,
		ST_J_EV,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_DONE
	} ctl_state_t;

endpackage
`default_nettype wire

[hdl/rect_area_allocator.sv]
// Allocate: best-fit scan, cut of overlapped entries into pieces, append of the pieces,
// containment sweep and compaction of the table. Restart reloads one atlas-sized entry.
// One item at a time; the pairwise sweep over the table RAM read port dominates.
// Reset: table holds one 1024x1024 rectangle one cycle after reset; overflow cleared.
// Top level of the rectangle area allocator: config registers, sequencer and datapath.
// Depends on raa_pkg, raa_ctrl, raa_dp.
`default_nettype none
module rect_area_allocator #(
	parameter int FREE_SLOTS = raa_pkg::FREE_SLOTS_DEF,
	parameter int COORD_MAX = raa_pkg::COORD_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire raa_pkg::cfg_reg_t cfg_index,
	input wire logic [raa_pkg::FIELD_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire raa_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output raa_pkg::out_item_t out_data
);
	import raa_pkg::*;

	logic [FIELD_W-1:0] atlas_w_q, atlas_h_q;
	dp_op_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= FIELD_W'(RESET_ATLAS);
			atlas_h_q <= FIELD_W'(RESET_ATLAS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ATLAS_WIDTH: atlas_w_q <= cfg_data;
				REG_ATLAS_HEIGHT: atlas_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	raa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_op(in_data.operation),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	raa_dp #(.FREE_SLOTS(FREE_SLOTS), .COORD_MAX(COORD_MAX)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_item(in_data),
		.atlas_w(atlas_w_q),
		.atlas_h(atlas_h_q),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_item(out_data)
	);
endmodule
`default_nettype wire

[hdl/raa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module raa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hdl/raa_ctrl.sv]
// Sequencer of the allocator: scan, cut, append, containment sweep, compaction.
// Depends on raa_pkg.
`default_nettype none
module raa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_op,
	output logic in_ready,
	input wire raa_pkg::dp_status_t status,
	output raa_pkg::dp_op_t cmd
);
	import raa_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd = OP_INIT;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op) begin
						state_d = ST_RESTART;
					end else begin
						cmd = OP_LOAD_REQ;
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_RESTART: begin
				cmd = OP_RESTART;
				state_d = ST_DONE;
			end
			ST_SCAN_RD: begin
				if (status.idx_end) begin
					if (status.found) begin
						cmd = OP_CUT_START;
						state_d = ST_CUT_RD;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd = OP_RD_IDX;
					state_d = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				cmd = OP_SCAN_EV;
				state_d = ST_SCAN_RD;
			end
			ST_CUT_RD: begin
				if (status.idx_end) begin
					cmd = OP_MOVE_START;
					state_d = ST_MOVE_RD;
				end else begin
					cmd = OP_RD_IDX;
					state_d = ST_CUT_EV;
				end
			end
			ST_CUT_EV: begin
				cmd = OP_CUT_EV;
				state_d = status.overlap ? ST_SPLIT : ST_CUT_RD;
			end
			ST_SPLIT: begin
				cmd = OP_SPLIT;
				state_d = status.split_last ? ST_CUT_RD : ST_SPLIT;
			end
			ST_MOVE_RD: begin
				if (status.move_end) begin
					cmd = OP_SW_START;
					state_d = ST_I_RD;
				end else begin
					cmd = OP_MOVE_RD;
					state_d = ST_MOVE_WR;
				end
			end
			ST_MOVE_WR: begin
				cmd = OP_MOVE_WR;
				state_d = ST_MOVE_RD;
			end
			ST_I_RD: begin
				if (status.idx_end) begin
					cmd = OP_CMP_START;
					state_d = ST_CMP_RD;
				end else if (status.idx_dead) begin
					cmd = OP_I_NEXT;
				end else begin
					cmd = OP_RD_IDX;
					state_d = ST_I_EV;
				end
			end
			ST_I_EV: begin
				cmd = OP_I_EV;
				state_d = ST_J_RD;
			end
			ST_J_RD: begin
				if (status.j_end) begin
					cmd = OP_I_NEXT;
					state_d = ST_I_RD;
				end else if (status.j_dead) begin
					cmd = OP_J_NEXT;
				end else begin
					cmd = OP_J_RD;
					state_d = ST_J_EV;
				end
			end
			ST_J_EV: begin
				cmd = OP_J_EV;
				state_d = status.i_in_j ? ST_I_RD : ST_J_RD;
			end
			ST_CMP_RD: begin
				if (status.idx_end) begin
					cmd = OP_CMP_END;
					state_d = ST_DONE;
				end else if (status.idx_dead) begin
					cmd = OP_I_NEXT;
				end else begin
					cmd = OP_RD_IDX;
					state_d = ST_CMP_WR;
				end
			end
			ST_CMP_WR: begin
				cmd = OP_CMP_WR;
				state_d = ST_CMP_RD;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

[hdl/raa_dp.sv]
// Datapath: free-rectangle table, piece buffer, best-fit scan, split and sweep logic.
// Depends on raa_pkg and raa_ram.
`default_nettype none
module raa_dp #(
	parameter int FREE_SLOTS = raa_pkg::FREE_SLOTS_DEF,
	parameter int COORD_MAX = raa_pkg::COORD_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire raa_pkg::dp_op_t cmd,
	output raa_pkg::dp_status_t status,
	input wire raa_pkg::in_item_t in_item,
	input wire logic [raa_pkg::FIELD_W-1:0] atlas_w,
	input wire logic [raa_pkg::FIELD_W-1:0] atlas_h,
	input wire logic out_ready,
	output logic out_valid,
	output raa_pkg::out_item_t out_item
);
	import raa_pkg::*;

	localparam int IW = $clog2(FREE_SLOTS);
	localparam int NW = $clog2(FREE_SLOTS + 1);
	localparam int CW = $clog2(COORD_MAX + 1);
	localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam int RW = 4 * CW;
	localparam int AW = 2 * CW;
	localparam logic [EW-1:0] CMAX = EW'(COORD_MAX);
	localparam logic [CW-1:0] INIT_SIDE = (RESET_ATLAS > COORD_MAX) ?
		CW'(COORD_MAX) : CW'(RESET_ATLAS);
	localparam logic [NW-1:0] SLOTS_N = NW'(FREE_SLOTS);
	localparam logic [NW-1:0] ONE_N = NW'(1);

	logic [EW-1:0] w_q, h_q;
	logic [NW-1:0] n_q, idx_q, j_q, s_q, p_q, k_q, cnt_q;
	logic [1:0] pc_q;
	logic found_q, ovf_q, out_valid_q;
	logic [AW-1:0] barea_q;
	logic [CW-1:0] bl_q, bt_q, cr_q, cb_q;
	logic [RW-1:0] o_q, ri_q;
	logic [FREE_SLOTS-1:0] dead_q;
	out_item_t out_q;

	logic t_we;
	logic [IW-1:0] t_waddr, t_raddr;
	logic [RW-1:0] t_wdata, t_rdata, p_rdata;
	logic p_we;

	logic [CW-1:0] rd_l, rd_t, rd_r, rd_b, o_l, o_t, o_r, o_b;
	logic [CW-1:0] ri_l, ri_t, ri_r, ri_b, fw, fh, sat_w, sat_h;
	logic [AW-1:0] area;
	logic fit, overlap, i_in_j, j_in_i, pc_cond, room, push;
	logic [RW-1:0] piece;
	logic [NW-1:0] wr_sum;

	assign {rd_l, rd_t, rd_r, rd_b} = t_rdata;
	assign {o_l, o_t, o_r, o_b} = o_q;
	assign {ri_l, ri_t, ri_r, ri_b} = ri_q;

	assign fw = (rd_r >= rd_l) ? rd_r - rd_l : '0;
	assign fh = (rd_b >= rd_t) ? rd_b - rd_t : '0;
	assign fit = (EW'(fw) >= w_q) && (EW'(fh) >= h_q);
	assign area = AW'(fw) * AW'(fh);

	assign overlap = (cr_q > rd_l) && (bl_q < rd_r) && (cb_q > rd_t) && (bt_q < rd_b);
	assign i_in_j = (ri_l >= rd_l) && (ri_t >= rd_t) && (ri_r <= rd_r) && (ri_b <= rd_b);
	assign j_in_i = (rd_l >= ri_l) && (rd_t >= ri_t) && (rd_r <= ri_r) && (rd_b <= ri_b);

	assign sat_w = (EW'(atlas_w) > CMAX) ? CW'(CMAX) : CW'(atlas_w);
	assign sat_h = (EW'(atlas_h) > CMAX) ? CW'(CMAX) : CW'(atlas_h);

	always_comb begin
		case (pc_q)
			2'd0: begin
				pc_cond = cr_q < o_r;
				piece = {cr_q, o_t, o_r, o_b};
			end
			2'd1: begin
				pc_cond = bl_q > o_l;
				piece = {o_l, o_t, bl_q, o_b};
			end
			2'd2: begin
				pc_cond = cb_q < o_b;
				piece = {o_l, cb_q, o_r, o_b};
			end
			default: begin
				pc_cond = bt_q > o_t;
				piece = {o_l, o_t, o_r, bt_q};
			end
		endcase
	end

	assign room = cnt_q < SLOTS_N;
	assign push = (cmd == OP_SPLIT) && pc_cond && room;
	assign p_we = push;
	assign wr_sum = s_q + k_q;
	assign t_raddr = (cmd == OP_J_RD) ? j_q[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		t_we = 1'b0;
		t_waddr = s_q[IW-1:0];
		t_wdata = t_rdata;
		unique case (cmd)
			OP_INIT: begin
				t_we = 1'b1;
				t_waddr = '0;
				t_wdata = {{CW{1'b0}}, {CW{1'b0}}, INIT_SIDE, INIT_SIDE};
			end
			OP_RESTART: begin
				t_we = 1'b1;
				t_waddr = '0;
				t_wdata = {{CW{1'b0}}, {CW{1'b0}}, sat_w, sat_h};
			end
			OP_CUT_EV: begin
				t_we = !overlap;
			end
			OP_MOVE_WR: begin
				t_we = 1'b1;
				t_waddr = wr_sum[IW-1:0];
				t_wdata = p_rdata;
			end
			OP_CMP_WR: begin
				t_we = 1'b1;
			end
			default: begin
				t_we = 1'b0;
			end
		endcase
	end

	raa_ram #(.WIDTH(RW), .DEPTH(FREE_SLOTS)) u_table (
		.clk(clk),
		.we(t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	raa_ram #(.WIDTH(RW), .DEPTH(FREE_SLOTS)) u_pieces (
		.clk(clk),
		.we(p_we),
		.waddr(p_q[IW-1:0]),
		.wdata(piece),
		.raddr(k_q[IW-1:0]),
		.rdata(p_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= ONE_N;
			ovf_q <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
			dead_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd)
				OP_INIT: begin
					n_q <= ONE_N;
				end
				OP_RESTART: begin
					n_q <= ONE_N;
					ovf_q <= 1'b0;
					found_q <= 1'b0;
				end
				OP_LOAD_REQ: begin
					w_q <= EW'(in_item.req_width);
					h_q <= EW'(in_item.req_height);
					idx_q <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_EV: begin
					if (fit && (!found_q || area < barea_q)) begin
						found_q <= 1'b1;
						barea_q <= area;
						bl_q <= rd_l;
						bt_q <= rd_t;
					end
					idx_q <= idx_q + ONE_N;
				end
				OP_CUT_START: begin
					cr_q <= bl_q + CW'(w_q);
					cb_q <= bt_q + CW'(h_q);
					idx_q <= '0;
					s_q <= '0;
					p_q <= '0;
					cnt_q <= n_q;
				end
				OP_CUT_EV: begin
					o_q <= t_rdata;
					pc_q <= 2'd0;
					if (!overlap) begin
						s_q <= s_q + ONE_N;
						idx_q <= idx_q + ONE_N;
					end
				end
				OP_SPLIT: begin
					if (push) begin
						p_q <= p_q + ONE_N;
					end
					if (pc_cond && !room) begin
						ovf_q <= 1'b1;
					end
					cnt_q <= cnt_q + NW'(push) - NW'(pc_q == 2'd3);
					pc_q <= pc_q + 2'd1;
					if (pc_q == 2'd3) begin
						idx_q <= idx_q + ONE_N;
					end
				end
				OP_MOVE_START: begin
					k_q <= '0;
				end
				OP_MOVE_WR: begin
					k_q <= k_q + ONE_N;
				end
				OP_SW_START: begin
					n_q <= s_q + p_q;
					dead_q <= '0;
					idx_q <= '0;
				end
				OP_I_NEXT: begin
					idx_q <= idx_q + ONE_N;
				end
				OP_I_EV: begin
					ri_q <= t_rdata;
					j_q <= idx_q + ONE_N;
				end
				OP_J_NEXT: begin
					j_q <= j_q + ONE_N;
				end
				OP_J_EV: begin
					if (i_in_j) begin
						dead_q[idx_q[IW-1:0]] <= 1'b1;
						idx_q <= idx_q + ONE_N;
					end else begin
						if (j_in_i) begin
							dead_q[j_q[IW-1:0]] <= 1'b1;
						end
						j_q <= j_q + ONE_N;
					end
				end
				OP_CMP_START: begin
					idx_q <= '0;
					s_q <= '0;
				end
				OP_CMP_WR: begin
					s_q <= s_q + ONE_N;
					idx_q <= idx_q + ONE_N;
				end
				OP_CMP_END: begin
					n_q <= s_q;
				end
				OP_RESULT: begin
					out_valid_q <= 1'b1;
					out_q.granted <= found_q;
					out_q.pos_x <= found_q ? FIELD_W'(bl_q) : '0;
					out_q.pos_y <= found_q ? FIELD_W'(bt_q) : '0;
					out_q.table_overflow <= ovf_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.idx_end = idx_q == n_q;
	assign status.j_end = j_q == n_q;
	assign status.idx_dead = dead_q[idx_q[IW-1:0]];
	assign status.j_dead = dead_q[j_q[IW-1:0]];
	assign status.found = found_q;
	assign status.overlap = overlap;
	assign status.split_last = pc_q == 2'd3;
	assign status.move_end = k_q == p_q;
	assign status.i_in_j = i_in_j;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= SLOTS_N) else $error("table count above capacity");
	a_restart_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == OP_RESTART |=> n_q == ONE_N) else $error("restart did not reload");
	a_cut_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == OP_CUT_EV |-> s_q <= idx_q) else $error("survivor overtakes read");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == OP_RESULT |=> out_valid_q) else $error("result beat lost");
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for rect_area_allocator: directed, random and backpressure tests.
// A predictor of the free-rectangle table checks every result beat in order.
// Depends on raa_pkg and the rect_area_allocator RTL.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import raa_pkg::*;

	localparam int SLOTS = FREE_SLOTS_DEF;
	localparam int CMAX = COORD_MAX_DEF;
	localparam longint LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_ATLAS_WIDTH;
	logic [FIELD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	rect_area_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// free table copy
	int unsigned fl[SLOTS], ft[SLOTS], fr[SLOTS], fb[SLOTS];
	int unsigned n_free;
	logic ovf_flag;
	int unsigned atlas_w, atlas_h;
	out_item_t grant_q[$];

	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_granted = 0;
	int n_ovf = 0;
	longint cycles = 0;
	int hold_cycles = 0;
	int stall_mode = 0;

	task automatic tbl_reload();
		n_free = 1;
		fl[0] = 0;
		ft[0] = 0;
		fr[0] = (atlas_w > CMAX) ? CMAX : atlas_w;
		fb[0] = (atlas_h > CMAX) ? CMAX : atlas_h;
		ovf_flag = 1'b0;
	endtask

	task automatic tbl_append(int unsigned l, int unsigned t, int unsigned r, int unsigned b);
		if (n_free < SLOTS) begin
			fl[n_free] = l; ft[n_free] = t; fr[n_free] = r; fb[n_free] = b;
			n_free++;
		end else begin
			ovf_flag = 1'b1;
		end
	endtask

	task automatic tbl_remove(int unsigned i);
		if (i < n_free) begin
			for (int unsigned k = i; k + 1 < n_free; k++) begin
				fl[k] = fl[k+1]; ft[k] = ft[k+1]; fr[k] = fr[k+1]; fb[k] = fb[k+1];
			end
			n_free--;
		end
	endtask

	function automatic bit encloses(int unsigned a, int unsigned c);
		return fl[a] >= fl[c] && ft[a] >= ft[c] && fr[a] <= fr[c] && fb[a] <= fb[c];
	endfunction

	task automatic predict_alloc(in_item_t it, output out_item_t res);
		int unsigned w, h, fw, fh, best, cl, ct, cr, cb, i, j, ol, ot, orr, ob;
		longint unsigned area, best_area;
		bit found, gone;
		res = '0;
		if (it.operation) begin
			tbl_reload();
			return;
		end
		w = it.req_width;
		h = it.req_height;
		found = 0;
		best = 0;
		best_area = 0;
		for (i = 0; i < n_free; i++) begin
			fw = (fr[i] >= fl[i]) ? fr[i] - fl[i] : 0;
			fh = (fb[i] >= ft[i]) ? fb[i] - ft[i] : 0;
			if (fw >= w && fh >= h) begin
				area = longint'(fw) * longint'(fh);
				if (!found || area < best_area) begin
					found = 1; best = i; best_area = area;
				end
			end
		end
		if (found) begin
			cl = fl[best]; ct = ft[best]; cr = cl + w; cb = ct + h;
			res.granted = 1'b1;
			res.pos_x = cl[FIELD_W-1:0];
			res.pos_y = ct[FIELD_W-1:0];
			i = 0;
			while (i < n_free) begin
				ol = fl[i]; ot = ft[i]; orr = fr[i]; ob = fb[i];
				if (cr > ol && cl < orr && cb > ot && ct < ob) begin
					if (cr < orr) tbl_append(cr, ot, orr, ob);
					if (cl > ol) tbl_append(ol, ot, cl, ob);
					if (cb < ob) tbl_append(ol, cb, orr, ob);
					if (ct > ot) tbl_append(ol, ot, orr, ct);
					tbl_remove(i);
				end else begin
					i++;
				end
			end
			i = 0;
			while (i < n_free) begin
				gone = 0;
				j = i + 1;
				while (j < n_free) begin
					if (encloses(i, j)) begin
						tbl_remove(i);
						gone = 1;
						break;
					end
					if (encloses(j, i)) tbl_remove(j);
					else j++;
				end
				if (!gone) i++;
			end
		end
		res.table_overflow = ovf_flag;
	endtask

	// result beat checker
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $realtime, out_data);
				errors++;
			end else begin
				exp_r = grant_q.pop_front();
				if (out_data.granted !== exp_r.granted) begin
					$display("%0t: granted exp %0d got %0d", $realtime, exp_r.granted,
						out_data.granted);
					errors++;
				end
				if (out_data.pos_x !== exp_r.pos_x) begin
					$display("%0t: pos_x exp %0d got %0d", $realtime, exp_r.pos_x,
						out_data.pos_x);
					errors++;
				end
				if (out_data.pos_y !== exp_r.pos_y) begin
					$display("%0t: pos_y exp %0d got %0d", $realtime, exp_r.pos_y,
						out_data.pos_y);
					errors++;
				end
				if (out_data.table_overflow !== exp_r.table_overflow) begin
					$display("%0t: table_overflow exp %0d got %0d", $realtime,
						exp_r.table_overflow, out_data.table_overflow);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern with an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(bit op, int unsigned w, int unsigned h);
		in_item_t it;
		out_item_t res;
		it.operation = op;
		it.req_width = w[FIELD_W-1:0];
		it.req_height = h[FIELD_W-1:0];
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_alloc(it, res);
		grant_q.push_back(res);
		n_items++;
		if (res.granted) n_granted++;
		if (res.table_overflow) n_ovf++;
	endtask

	task automatic gap(int unsigned n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		gap(1);
		while (grant_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[FIELD_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ATLAS_WIDTH) atlas_w = val & 13'h1FFF;
		else atlas_h = val & 13'h1FFF;
		@(posedge clk);
	endtask

	task automatic rand_size(output int unsigned w, output int unsigned h);
		case ($urandom_range(0, 9))
			0: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
			1: begin w = $urandom_range(0, 4096); h = $urandom_range(0, 16); end
			default: begin w = $urandom_range(1, 200); h = $urandom_range(1, 200); end
		endcase
	endtask

	task automatic test_reset_table();
		send_item(0, 1024, 1024);
		send_item(0, 1, 1);
		send_item(0, 0, 0);
		send_item(1, 0, 0);
		send_item(0, 1025, 1);
		send_item(0, 0, 0);
		send_item(0, 512, 300);
		send_item(0, 100, 800);
		drain();
	endtask

	task automatic test_atlas_extremes();
		write_reg(REG_ATLAS_WIDTH, 0);
		write_reg(REG_ATLAS_HEIGHT, 0);
		send_item(1, 8191, 8191);
		send_item(0, 0, 0);
		send_item(0, 1, 0);
		drain();
		write_reg(REG_ATLAS_WIDTH, 8191);
		write_reg(REG_ATLAS_HEIGHT, 8191);
		send_item(1, 0, 0);
		send_item(0, 4097, 1);
		send_item(0, 4096, 4096);
		send_item(1, 0, 0);
		send_item(0, 8191, 8191);
		send_item(0, 4096, 1);
		drain();
		write_reg(REG_ATLAS_WIDTH, 1);
		write_reg(REG_ATLAS_HEIGHT, 4096);
		send_item(1, 0, 0);
		send_item(0, 1, 4096);
		send_item(0, 0, 0);
		drain();
	endtask

	task automatic test_random_bursts();
		int unsigned w, h, burst;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_ATLAS_WIDTH, (ph == 0) ? 4096 : $urandom_range(64, 8191));
			write_reg(REG_ATLAS_HEIGHT, (ph == 3) ? 1 : $urandom_range(64, 8191));
			send_item(1, $urandom_range(0, 8191), $urandom_range(0, 8191));
			for (int k = 0; k < 20;) begin
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst; b++) begin
					rand_size(w, h);
					send_item($urandom_range(0, 15) == 0, w, h);
					k++;
				end
				gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
			end
			drain();
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_ATLAS_WIDTH, 1024);
		write_reg(REG_ATLAS_HEIGHT, 1024);
		send_item(1, 0, 0);
		hold_cycles = 3000;
		for (int k = 0; k < 12; k++) send_item(0, $urandom_range(1, 300), $urandom_range(1, 300));
		drain();
	endtask

	initial begin
		atlas_w = RESET_ATLAS;
		atlas_h = RESET_ATLAS;
		tbl_reload();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_reset_table();
		test_atlas_extremes();
		test_random_bursts();
		test_backpressure();
		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d items, %0d results, %0d granted, %0d with overflow set.",
			n_items, n_results, n_granted, n_ovf);
		if (errors == 0 && grant_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
